@@ sv/lpg_pkg.sv @@
`default_nettype none

package lpg_pkg;

	localparam int CoordW = 12;
	localparam int ErrW   = 14;

	localparam logic       OP_START = 1'b0;
	localparam logic       OP_STEP  = 1'b1;

	localparam logic [1:0] MODE_VERT = 2'd0;
	localparam logic [1:0] MODE_HORZ = 2'd1;
	localparam logic [1:0] MODE_XMAJ = 2'd2;
	localparam logic [1:0] MODE_YMAJ = 2'd3;

	typedef struct packed {
		logic                     active;
		logic [1:0]               line_mode;
		logic signed [CoordW-1:0] major_pos;
		logic signed [CoordW-1:0] minor_pos;
		logic signed [CoordW-1:0] major_end;
		logic signed [ErrW-1:0]   error_term;
		logic [CoordW-1:0]        major_delta;
		logic [CoordW-1:0]        minor_delta;
		logic                     major_dir;
		logic                     minor_dir;
	} line_state_t;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic                     last;
	} pixel_t;

endpackage

`default_nettype wire

@@ sv/lpg_setup.sv @@
`default_nettype none

module lpg_setup (
	input  wire logic signed [lpg_pkg::CoordW-1:0] start_x,
	input  wire logic signed [lpg_pkg::CoordW-1:0] start_y,
	input  wire logic signed [lpg_pkg::CoordW-1:0] end_x,
	input  wire logic signed [lpg_pkg::CoordW-1:0] end_y,
	output lpg_pkg::line_state_t                   init
);

	logic signed [lpg_pkg::CoordW:0] dx, dy;
	logic [lpg_pkg::CoordW-1:0]      adx, ady;
	logic [lpg_pkg::CoordW:0]        ndx, ndy;

	assign dx  = {end_x[lpg_pkg::CoordW-1], end_x} - {start_x[lpg_pkg::CoordW-1], start_x};
	assign dy  = {end_y[lpg_pkg::CoordW-1], end_y} - {start_y[lpg_pkg::CoordW-1], start_y};
	assign ndx = -dx;
	assign ndy = -dy;
	assign adx = dx[lpg_pkg::CoordW] ? ndx[lpg_pkg::CoordW-1:0] : dx[lpg_pkg::CoordW-1:0];
	assign ady = dy[lpg_pkg::CoordW] ? ndy[lpg_pkg::CoordW-1:0] : dy[lpg_pkg::CoordW-1:0];

	always_comb begin
		init = '0;
		init.active = 1'b1;
		if (start_x == end_x) begin
			init.line_mode = lpg_pkg::MODE_VERT;
			init.minor_pos = start_x;
			init.major_pos = (start_y < end_y) ? start_y : end_y;
			init.major_end = (start_y < end_y) ? end_y : start_y;
		end else if (start_y == end_y) begin
			init.line_mode = lpg_pkg::MODE_HORZ;
			init.minor_pos = start_y;
			init.major_pos = (start_x < end_x) ? start_x : end_x;
			init.major_end = (start_x < end_x) ? end_x : start_x;
		end else if (adx >= ady) begin
			init.line_mode   = lpg_pkg::MODE_XMAJ;
			init.major_pos   = start_x;
			init.minor_pos   = start_y;
			init.major_end   = end_x;
			init.major_delta = adx;
			init.minor_delta = ady;
			init.major_dir   = dx[lpg_pkg::CoordW];
			init.minor_dir   = dy[lpg_pkg::CoordW];
			init.error_term  = $signed({2'b00, ady} - {2'b00, adx});
		end else begin
			init.line_mode   = lpg_pkg::MODE_YMAJ;
			init.major_pos   = start_y;
			init.minor_pos   = start_x;
			init.major_end   = end_y;
			init.major_delta = ady;
			init.minor_delta = adx;
			init.major_dir   = dy[lpg_pkg::CoordW];
			init.minor_dir   = dx[lpg_pkg::CoordW];
			init.error_term  = $signed({2'b00, adx} - {2'b00, ady});
		end
	end

endmodule

`default_nettype wire

@@ sv/lpg_step.sv @@
`default_nettype none

module lpg_step (
	input  wire lpg_pkg::line_state_t cur,
	output lpg_pkg::line_state_t      nxt,
	output lpg_pkg::pixel_t           pix
);

	logic signed [lpg_pkg::CoordW-1:0] maj_next, min_next;
	logic [lpg_pkg::ErrW-1:0]          err_a, err_b;
	logic                              is_axis;

	assign is_axis = (cur.line_mode == lpg_pkg::MODE_VERT) ||
	                 (cur.line_mode == lpg_pkg::MODE_HORZ);

	assign maj_next = (!is_axis && cur.major_dir) ? cur.major_pos - 12'sd1
	                                              : cur.major_pos + 12'sd1;
	assign min_next = cur.minor_dir ? cur.minor_pos - 12'sd1 : cur.minor_pos + 12'sd1;

	// error >= 0: minor steps and error drops by major delta
	assign err_a = cur.error_term[lpg_pkg::ErrW-1]
	               ? cur.error_term
	               : cur.error_term - {2'b00, cur.major_delta};
	assign err_b = err_a + {2'b00, cur.minor_delta};

	always_comb begin
		nxt = cur;
		if ((cur.line_mode == lpg_pkg::MODE_HORZ) || (cur.line_mode == lpg_pkg::MODE_XMAJ)) begin
			pix.x = cur.major_pos;
			pix.y = cur.minor_pos;
		end else begin
			pix.x = cur.minor_pos;
			pix.y = cur.major_pos;
		end
		if (is_axis) begin
			pix.last = (cur.major_pos == cur.major_end);
		end else begin
			pix.last = (maj_next == cur.major_end);
			nxt.error_term = $signed(err_b);
			if (!cur.error_term[lpg_pkg::ErrW-1]) begin
				nxt.minor_pos = min_next;
			end
		end
		nxt.major_pos = maj_next;
		nxt.active    = !pix.last;
	end

endmodule

`default_nettype wire

@@ sv/line_pixel_generator.sv @@
// Channel | Dir | Payload
// s_axis  | in  | tuser: op; tdata: start_x, start_y, end_x, end_y
// m_axis  | out | tuser: pixel_valid, in_grid; tdata: pixel_x, pixel_y; tlast: last_pixel
//
// One word in, one word out; a new word may be taken every cycle.
// An input word passes the input register, then setup and step logic into the output register.
// The line state loop (position and error-term updates, end compare) closes through state_q alone.
// Reset clears the line state and both valid flags; no line is active afterwards.
// A stalled output holds its word; the input register takes one more word meanwhile, then s_axis_tready drops.
`default_nettype none

module line_pixel_generator #(
	parameter int GRID_SIZE = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // start_x, start_y, end_x, end_y
	input  wire logic        s_axis_tuser,  // op
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // pixel_x, pixel_y
	output logic [1:0]       m_axis_tuser,  // pixel_valid, in_grid
	output logic             m_axis_tlast
);

	localparam logic [lpg_pkg::CoordW:0] GridLim = (lpg_pkg::CoordW+1)'(GRID_SIZE);

	logic                 valid_s1;
	logic                 op_s1;
	logic [47:0]          data_s1;
	logic                 advance;
	logic                 take_in;
	lpg_pkg::line_state_t state_q, init, cur, nxt;
	lpg_pkg::pixel_t      pix;
	logic                 in_grid;

	assign advance       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	lpg_setup u_setup (
		.start_x (data_s1[11:0]),
		.start_y (data_s1[23:12]),
		.end_x   (data_s1[35:24]),
		.end_y   (data_s1[47:36]),
		.init    (init)
	);

	assign cur = (op_s1 == lpg_pkg::OP_START) ? init : state_q;

	lpg_step u_step (
		.cur (cur),
		.nxt (nxt),
		.pix (pix)
	);

	assign in_grid = !pix.x[lpg_pkg::CoordW-1] && !pix.y[lpg_pkg::CoordW-1] &&
	                 ({1'b0, pix.x} < GridLim) && ({1'b0, pix.y} < GridLim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1   <= s_axis_tuser;
			data_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= '0;
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= valid_s1;
			if (valid_s1) begin
				state_q <= cur.active ? nxt : cur;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			if (cur.active) begin
				m_axis_tdata <= {pix.y, pix.x};
				m_axis_tuser <= {in_grid, 1'b1};
				m_axis_tlast <= pix.last;
			end else begin
				m_axis_tdata <= '0;
				m_axis_tuser <= '0;
				m_axis_tlast <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ dv/tb_line_pixel_generator.sv @@
`timescale 1ns / 1ps

module tb_line_pixel_generator;

	import lpg_pkg::*;

	localparam int GRID  = 512;
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic              valid;
		logic signed [11:0] x;
		logic signed [11:0] y;
		logic              in_grid;
		logic              last;
	} pix_t;

	typedef struct {
		logic        op;
		logic [47:0] data;
		bit          drain;
		int          phase;
	} cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // start_x, start_y, end_x, end_y
	logic        s_axis_tuser = 1'b0; // op
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // pixel_x, pixel_y
	logic [1:0]  m_axis_tuser;        // pixel_valid, in_grid
	logic        m_axis_tlast;

	cmd_t cmd_q[$];
	pix_t pixel_q[$];

	int  idle_pct[3]  = '{22, 58, 0};
	int  stall_pct[3] = '{58, 22, 0};
	int  tx_phase = 0;
	int  gen_phase = 0;
	bit  drain_next = 0;
	bit  in_fire = 0;
	int  words_in = 0;
	int  words_out = 0;
	int  cmd_total = 0;
	int  errors = 0;
	int  cycle_count = 0;

	// predictor line state
	bit         ln_active = 0;
	logic [1:0] ln_mode = MODE_VERT;
	int         ln_major = 0;
	int         ln_minor = 0;
	int         ln_end = 0;
	int         ln_err = 0;
	int         ln_dmaj = 0;
	int         ln_dmin = 0;
	bit         ln_majdec = 0;
	bit         ln_mindec = 0;

	line_pixel_generator #(.GRID_SIZE(GRID)) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic int wrap_coord(input int v);
		logic signed [11:0] t;
		t = v[11:0];
		return int'(t);
	endfunction

	function automatic int wrap_err(input int v);
		logic signed [13:0] t;
		t = v[13:0];
		return int'(t);
	endfunction

	function automatic int iabs(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int clamp_coord(input int v);
		return (v < -2048) ? -2048 : ((v > 2047) ? 2047 : v);
	endfunction

	function automatic pix_t plot_next(input logic op, input logic [47:0] d);
		int ax, ay, cx, cy, dx, dy, adx, ady, px, py, nxt;
		bit last;
		pix_t p;
		p = '0;
		if (op == OP_START) begin
			ax = int'($signed(d[11:0]));
			ay = int'($signed(d[23:12]));
			cx = int'($signed(d[35:24]));
			cy = int'($signed(d[47:36]));
			dx = cx - ax;
			dy = cy - ay;
			adx = iabs(dx);
			ady = iabs(dy);
			ln_active = 1;
			ln_err = 0;
			ln_dmaj = 0;
			ln_dmin = 0;
			ln_majdec = 0;
			ln_mindec = 0;
			if (ax == cx) begin
				ln_mode = MODE_VERT;
				ln_minor = ax;
				ln_major = (ay < cy) ? ay : cy;
				ln_end = (ay < cy) ? cy : ay;
			end else if (ay == cy) begin
				ln_mode = MODE_HORZ;
				ln_minor = ay;
				ln_major = (ax < cx) ? ax : cx;
				ln_end = (ax < cx) ? cx : ax;
			end else if (adx >= ady) begin
				ln_mode = MODE_XMAJ;
				ln_major = ax;
				ln_minor = ay;
				ln_end = cx;
				ln_dmaj = adx;
				ln_dmin = ady;
				ln_majdec = dx < 0;
				ln_mindec = dy < 0;
				ln_err = ady - adx;
			end else begin
				ln_mode = MODE_YMAJ;
				ln_major = ay;
				ln_minor = ax;
				ln_end = cy;
				ln_dmaj = ady;
				ln_dmin = adx;
				ln_majdec = dy < 0;
				ln_mindec = dx < 0;
				ln_err = adx - ady;
			end
		end
		if (!ln_active)
			return p;
		if (ln_mode == MODE_HORZ || ln_mode == MODE_XMAJ) begin
			px = ln_major;
			py = ln_minor;
		end else begin
			px = ln_minor;
			py = ln_major;
		end
		if (ln_mode == MODE_VERT || ln_mode == MODE_HORZ) begin
			last = (ln_major == ln_end);
			ln_major = wrap_coord(ln_major + 1);
		end else begin
			nxt = wrap_coord(ln_majdec ? ln_major - 1 : ln_major + 1);
			last = (nxt == ln_end);
			if (ln_err >= 0) begin
				ln_minor = wrap_coord(ln_mindec ? ln_minor - 1 : ln_minor + 1);
				ln_err = wrap_err(ln_err - ln_dmaj);
			end
			ln_err = wrap_err(ln_err + ln_dmin);
			ln_major = nxt;
		end
		if (last)
			ln_active = 0;
		p.valid = 1'b1;
		p.x = px[11:0];
		p.y = py[11:0];
		p.in_grid = (px >= 0 && px < GRID && py >= 0 && py < GRID);
		p.last = last;
		return p;
	endfunction

	task automatic push_cmd(input logic op, input int sx, input int sy, input int ex, input int ey);
		cmd_t c;
		c.op = op;
		c.data = {ey[11:0], ex[11:0], sy[11:0], sx[11:0]};
		c.drain = drain_next;
		c.phase = gen_phase;
		drain_next = 0;
		cmd_q.insert(cmd_q.size(), c);
		cmd_total++;
	endtask

	// step words carry random data, which the block must ignore
	task automatic push_step(input int n);
		for (int i = 0; i < n; i++)
			push_cmd(OP_STEP, $urandom, $urandom, $urandom, $urandom);
	endtask

	// start a line, then at most cap steps of it, then extra steps
	task automatic draw(input int sx, input int sy, input int ex, input int ey,
			input int cap, input int extra);
		int len;
		if (sx == ex)
			len = iabs(ey - sy) + 1;
		else if (sy == ey)
			len = iabs(ex - sx) + 1;
		else
			len = (iabs(ex - sx) >= iabs(ey - sy)) ? iabs(ex - sx) : iabs(ey - sy);
		push_cmd(OP_START, sx, sy, ex, ey);
		push_step(((len - 1 < cap) ? len - 1 : cap) + extra);
	endtask

	function automatic int pick_coord();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return -2048;
		if (r < 10)
			return 2047;
		if (r < 60)
			return int'($urandom_range(527)) - 8;
		return int'($urandom_range(4095)) - 2048;
	endfunction

	task automatic random_traffic(input int n);
		int kind, ox, oy, dx, dy, extra, cap;
		while (cmd_total < n) begin
			kind = $urandom_range(99);
			if ($urandom_range(99) == 0)
				drain_next = 1;
			if (kind < 70) begin
				ox = pick_coord();
				oy = pick_coord();
				dx = int'($urandom_range(40)) - 20;
				dy = int'($urandom_range(40)) - 20;
				case ($urandom_range(19))
					0, 1, 2: dx = 0;
					3, 4, 5: dy = 0;
					6: begin
						dx = 0;
						dy = 0;
					end
					7: dy = ($urandom_range(1) != 0) ? dx : -dx;
					default: ;
				endcase
				extra = 0;
				cap = 1 << 20;
				kind = $urandom_range(99);
				if (kind < 7)
					extra = $urandom_range(1, 3);
				else if (kind < 15)
					cap = $urandom_range(0, 10);
				draw(ox, oy, clamp_coord(ox + dx), clamp_coord(oy + dy), cap, extra);
			end else if (kind < 80) begin
				draw(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
					$urandom_range(10, 40), 0);
			end else if (kind < 90) begin
				push_cmd(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
			end else begin
				ox = pick_coord();
				oy = pick_coord();
				dx = int'($urandom_range(60)) - 30;
				if ($urandom_range(1) != 0)
					draw(ox, oy, ox, clamp_coord(oy + dx), 1 << 20, 0);
				else
					draw(ox, oy, clamp_coord(ox + dx), oy, 1 << 20, 0);
			end
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on word %0d, %s: got %0d, expected %0d", words_out, what, got, want);
		errors++;
	endtask

	always @(negedge clk) begin
		cmd_t c;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_fire) begin
			if (cmd_q.size() != 0 && (!cmd_q[0].drain || pixel_q.size() == 0)
					&& $urandom_range(99) >= idle_pct[cmd_q[0].phase]) begin
				c = cmd_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= c.data;
				s_axis_tuser <= c.op;
				tx_phase <= c.phase;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= ($urandom_range(99) >= stall_pct[tx_phase]);
	end

	always @(posedge clk) begin
		pix_t want;
		cycle_count++;
		in_fire <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pixel_q.size() == 0) begin
				report_mismatch("word with nothing expected", 0, 0);
			end else begin
				want = pixel_q.pop_front();
				if (m_axis_tuser[0] !== want.valid)
					report_mismatch("pixel_valid", m_axis_tuser[0], want.valid);
				if ($signed(m_axis_tdata[11:0]) !== want.x)
					report_mismatch("pixel_x", int'($signed(m_axis_tdata[11:0])), int'(want.x));
				if ($signed(m_axis_tdata[23:12]) !== want.y)
					report_mismatch("pixel_y", int'($signed(m_axis_tdata[23:12])), int'(want.y));
				if (m_axis_tuser[1] !== want.in_grid)
					report_mismatch("in_grid", m_axis_tuser[1], want.in_grid);
				if (m_axis_tlast !== want.last)
					report_mismatch("last_pixel", m_axis_tlast, want.last);
			end
			words_out++;
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			pixel_q.insert(pixel_q.size(), plot_next(s_axis_tuser, s_axis_tdata));
			words_in++;
		end
		if (cycle_count >= LIMIT) begin
			$display("tb_line_pixel_generator: FAIL");
			$finish;
		end
	end

	initial begin
		gen_phase = 0;
		// step while idle
		push_step(1);
		// both endpoints equal, then idle again
		draw(0, 0, 0, 0, 1 << 20, 1);
		// vertical and horizontal at the extremes, drawn from the higher end
		draw(-2048, 2047, -2048, 2045, 1 << 20, 0);
		draw(2047, 2047, 2045, 2047, 1 << 20, 0);
		// x-major and y-major both leaving the grid, diagonal tie
		draw(511, 0, 508, -2, 1 << 20, 0);
		draw(0, 511, 1, 515, 1 << 20, 0);
		draw(10, 10, 13, 13, 1 << 20, 0);
		// restart while active
		draw(-2048, -2048, 2047, 2047, 1, 0);
		draw(0, 0, 0, 1, 1, 0);

		for (int ph = 0; ph < 3; ph++) begin
			gen_phase = ph;
			drain_next = 1;
			random_traffic(cmd_total + 525);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (words_in < cmd_total || pixel_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("tb_line_pixel_generator: PASS");
		else
			$display("tb_line_pixel_generator: FAIL");
		$finish;
	end

endmodule

@@ files.f @@
sv/lpg_pkg.sv
sv/lpg_setup.sv
sv/lpg_step.sv
sv/line_pixel_generator.sv
dv/tb_line_pixel_generator.sv
